/* sv/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants of the pell solver
// ----------------------------------------------------------------------------
`default_nettype none
package pfs_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SQUARE   = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam int MAX_TERMS = 256;
  localparam int TERM_BITS = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_STEP_A,
    ST_STEP_B,
    ST_DIV_B,
    ST_CHECK,
    ST_DIV_A,
    ST_GUARD,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic calc_a;
    logic calc_b;
    logic div_b_start;
    logic div_a_start;
    logic div_step;
    logic update;
    logic set_ok;
    logic set_square;
    logic set_overflow;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic is_square;
    logic div_done;
    logic bad_a;
    logic bn_one;
    logic bn_zero;
    logic odd_term;
    logic guard_hit;
    logic overflow;
  } sts_t;

endpackage
`default_nettype wire

/* sv/pell_fundamental_solution.sv */
// sequence: a root search, then two serial divides per continued
// fraction term and one for the closing term
// one item at a time; a new radicand is taken only in idle, after the result has been accepted
// reset: synchronous, returns the sequencer to idle; result held until taken
// ----------------------------------------------------------------------------
// pell_fundamental_solution
// fundamental solution of x^2 - n*y^2 = 1 by continued fractions
// ----------------------------------------------------------------------------
`default_nettype none
module pell_fundamental_solution
  import pfs_pkg::*;
#(
  parameter int RADICAND_BITS = 7,
  parameter int RESULT_BITS   = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [6:0]  radicand,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [62:0] sol_x,
  output logic [62:0] sol_y,
  output logic [1:0]  status
);

  cmd_t cmd;
  sts_t sts;

  pfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  pfs_dp #(.RADICAND_BITS(RADICAND_BITS), .RESULT_BITS(RESULT_BITS)) u_dp (
    .clk(clk), .radicand(radicand), .cmd(cmd), .sts(sts),
    .sol_x(sol_x), .sol_y(sol_y), .status(status)
  );

endmodule
`default_nettype wire

/* sv/pfs_ctrl.sv */
// ----------------------------------------------------------------------------
// pfs_ctrl
// sequencer for the continued fraction expansion
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_ctrl
  import pfs_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SQRT;
      ST_SQRT:   if (sts.sqrt_done) begin
        state_next = sts.is_square ? ST_DONE : ST_STEP_A;
      end
      ST_STEP_A: state_next = ST_STEP_B;
      ST_STEP_B: state_next = (sts.bad_a || sts.guard_hit) ? ST_DONE : ST_DIV_B;
      ST_DIV_B:  if (sts.div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if ((sts.odd_term && sts.bn_one) || sts.bn_zero) state_next = ST_DONE;
        else state_next = ST_DIV_A;
      end
      ST_DIV_A:  if (sts.div_done) state_next = ST_GUARD;
      ST_GUARD:  state_next = sts.overflow ? ST_DONE : ST_UPDATE;
      ST_UPDATE: state_next = ST_STEP_A;
      ST_DONE:   if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.set_square = sts.sqrt_done && sts.is_square;
      end
      ST_STEP_A: cmd.calc_a = 1'b1;
      ST_STEP_B: begin
        cmd.calc_b = 1'b1;
        cmd.div_b_start = !(sts.bad_a || sts.guard_hit);
      end
      ST_DIV_B:  cmd.div_step = 1'b1;
      ST_CHECK: begin
        cmd.set_ok = sts.odd_term && sts.bn_one;
        cmd.div_a_start = !((sts.odd_term && sts.bn_one) || sts.bn_zero);
      end
      ST_DIV_A:  cmd.div_step = 1'b1;
      ST_GUARD:  cmd.set_overflow = sts.overflow;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DONE:   out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/pfs_dp.sv */
// ----------------------------------------------------------------------------
// pfs_dp
// datapath: square root search, shared serial divider, convergent registers
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_dp
  import pfs_pkg::*;
#(
  parameter int RADICAND_BITS = 7,
  parameter int RESULT_BITS   = 64
) (
  input  wire                      clk,
  input  wire  [6:0]               radicand,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [62:0]              sol_x,
  output logic [62:0]              sol_y,
  output logic [1:0]               status
);

  localparam int NB = RADICAND_BITS;
  localparam int RB = RESULT_BITS;
  localparam int DB = NB + 1;
  localparam int DCW = $clog2(DB + 1);
  localparam logic [RB-1:0] LIMIT = {1'b0, {(RB-1){1'b1}}};

  // recurrence values stay below 2*sqrt(n)
  logic [NB-1:0] n, a0, root, a_term, a_new, bv;
  logic [NB:0]   av, a_next;
  logic [RB-1:0] pm1, pm2, qm1, qm2;
  logic [TERM_BITS-1:0] k;

  // serial restoring divider
  logic [DB-1:0]  dividend, divisor, quo, rem;
  logic [DCW-1:0] dcnt;

  logic [2*NB+1:0] prod_ab, a_sq;
  logic [RB+DB-1:0] pp, qq;
  logic [RB-1:0]   pnew, qnew;

  assign prod_ab = (2*NB+2)'(a_term) * (2*NB+2)'(bv);
  assign a_sq    = (2*NB+2)'(a_next) * (2*NB+2)'(a_next);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= radicand[NB-1:0];
      root <= '0;
      status <= STATUS_OVERFLOW;
      sol_x <= '0;
      sol_y <= '0;
    end
    if (cmd.sqrt_step && !sts.sqrt_done) root <= root + 1'b1;
    if (cmd.sqrt_step && sts.sqrt_done) begin
      a0 <= root;
      a_term <= root;
      av <= '0;
      bv <= NB'(1);
      pm2 <= RB'(1);
      pm1 <= RB'(root);
      qm2 <= '0;
      qm1 <= RB'(1);
      k <= '0;
    end
    if (cmd.set_square) status <= STATUS_SQUARE;
    if (cmd.calc_a) a_next <= (NB+1)'(prod_ab - (2*NB+2)'(av));
    if (cmd.div_b_start) begin
      dividend <= DB'((2*NB+2)'(n) - a_sq);
      divisor <= DB'(bv);
      rem <= '0;
      dcnt <= DCW'(DB);
    end
    if (cmd.div_a_start) begin
      dividend <= DB'(a0) + DB'(a_next);
      divisor <= quo;
      a_new <= NB'(quo);
      rem <= '0;
      dcnt <= DCW'(DB);
    end
    if (cmd.div_step && dcnt != '0) begin
      if ({rem, dividend[DB-1]} >= {1'b0, divisor}) begin
        rem <= DB'({rem, dividend[DB-1]} - {1'b0, divisor});
        dividend <= {dividend[DB-2:0], 1'b1};
      end else begin
        rem <= {rem[DB-2:0], dividend[DB-1]};
        dividend <= {dividend[DB-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.div_step && dcnt == '0) quo <= dividend;
    if (cmd.set_ok) begin
      status <= STATUS_OK;
      sol_x <= 63'(pm1);
      sol_y <= 63'(qm1);
    end
    if (cmd.update) begin
      av <= a_next;
      bv <= a_new;
      a_term <= NB'(quo);
      pm2 <= pm1;
      pm1 <= pnew;
      qm2 <= qm1;
      qm1 <= qnew;
      k <= k + 1'b1;
    end
  end

  // in the divide a state quo is the b term; a_new holds it for update
  assign pp = (RB+DB)'(quo) * (RB+DB)'(pm1);
  assign qq = (RB+DB)'(quo) * (RB+DB)'(qm1);
  assign pnew = pp[RB-1:0] + pm2;
  assign qnew = qq[RB-1:0] + qm2;

  always_comb begin
    sts = '0;
    sts.sqrt_done = (2*NB+2)'(root + 1'b1) * (2*NB+2)'(root + 1'b1)
                    > (2*NB+2)'(n) || root == '1;
    sts.is_square = (2*NB+2)'(root) * (2*NB+2)'(root) == (2*NB+2)'(n);
    sts.div_done  = dcnt == '0;
    sts.bad_a     = bv == '0 || a_sq > (2*NB+2)'(n) || a_next[NB];
    sts.bn_one    = dividend == DB'(1);
    sts.bn_zero   = dividend == '0;
    sts.odd_term  = k[0];
    sts.guard_hit = k == TERM_BITS'(MAX_TERMS);
    sts.overflow  = pp[RB+DB-1:RB] != '0 || pnew > LIMIT || pnew < pm2
                    || qq[RB+DB-1:RB] != '0 || qnew > LIMIT || qnew < qm2;
  end

endmodule
`default_nettype wire

/* sv/pfs_checker.sv */
// ----------------------------------------------------------------------------
// pfs_checker
// port level checks of the pell solver
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_checker
  import pfs_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [62:0] sol_x,
  input wire [62:0] sol_y,
  input wire [1:0]  status
);

  // one item at a time
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> sol_x == '0 && sol_y == '0)
    else $error("nonzero solution with error status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sol_x) && $stable(status))
    else $error("result dropped");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status");

endmodule

bind pell_fundamental_solution pfs_checker u_chk (.*);
`default_nettype wire
